/* src/amavg_pkg.sv */
// Package for the angle moving average block: sizes, types, angle constants
// and request codes. No dependencies.
`default_nettype none
package amavg_pkg;

  localparam int WINDOW_DEPTH = 5;

  localparam int ANGLE_W = 9;
  localparam int OUT_W   = 10;
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  // worst sample after the wrap adjustment is 179 + 360
  localparam int SUM_W   = $clog2(WINDOW_DEPTH * 539 + 1);
  localparam int STEP_W  = $clog2(SUM_W + 1);

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [OUT_W-1:0]   res_t;

  localparam angle_t ANGLE_MAX = 9'd359;
  localparam angle_t FULL_TURN = 9'd360;
  localparam angle_t HALF_TURN = 9'd180;
  localparam angle_t LOW_EDGE  = 9'd90;
  localparam angle_t HIGH_EDGE = 9'd270;
  localparam res_t   RES_EMPTY = '1;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic   upd;
    logic   clr;
    angle_t angle;
  } win_cmd_t;

endpackage
`default_nettype wire

/* src/angle_moving_average_wrap.sv */
// Top level of the angle moving average with wrap at 0/360 degrees.
// Depends on amavg_pkg, amavg_window and amavg_div.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, req_type, angle | into block
//   out     | out_valid, out_stall, smoothed_angle | out of block
//
// One transaction in gives one transaction out. A transaction is a scan of
// the window, one entry a cycle, then the bit-serial divide by the count. An
// empty window skips the divide. Reset clears the count and control state. A
// result held by out_stall waits in the output register; the next input
// transaction is taken once the block is idle again.
`default_nettype none
module angle_moving_average_wrap (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             req_type,
  input  wire  [amavg_pkg::ANGLE_W-1:0]   angle,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [amavg_pkg::OUT_W-1:0] smoothed_angle
);
  import amavg_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DSTA = 3'd2;
  localparam logic [2:0] ST_DWAI = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state;
  win_cmd_t   cmd;
  idx_t       idx;
  angle_t     rd_data;
  cnt_t       count;
  sum_t       raw_sum;
  sum_t       adj_sum;
  logic       has_low;
  logic       has_high;
  logic       div_start;
  logic       div_done;
  sum_t       quotient;
  res_t       res;
  res_t       mean;
  logic       in_acc;

  assign in_stall  = rst || (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign div_start = (state == ST_DSTA);
  assign mean      = quotient[OUT_W-1:0];

  always_comb begin
    cmd.upd   = in_acc;
    cmd.clr   = req_type;
    cmd.angle = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
  end

  amavg_window u_window (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_idx  (idx),
    .rd_data (rd_data),
    .count   (count)
  );

  amavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((has_low && has_high) ? adj_sum : raw_sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (count == '0) begin
            state <= ST_FIN;
          end else if (CNT_W'(idx) + 1'b1 == count) begin
            state <= ST_DSTA;
          end
        end
        ST_DSTA: state <= ST_DWAI;
        ST_DWAI: begin
          if (div_done) state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx      <= '0;
      raw_sum  <= '0;
      adj_sum  <= '0;
      has_low  <= 1'b0;
      has_high <= 1'b0;
    end else if (state == ST_SCAN && count != '0) begin
      idx      <= idx + 1'b1;
      raw_sum  <= raw_sum + SUM_W'(rd_data);
      adj_sum  <= adj_sum + SUM_W'(rd_data)
                  + ((rd_data < HALF_TURN) ? SUM_W'(FULL_TURN) : '0);
      if (rd_data < LOW_EDGE)  has_low  <= 1'b1;
      if (rd_data > HIGH_EDGE) has_high <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && count == '0) begin
      res <= RES_EMPTY;
    end else if (state == ST_DWAI && div_done) begin
      res <= (mean >= OUT_W'(FULL_TURN)) ? mean - OUT_W'(FULL_TURN) : mean;
    end
    if (state == ST_FIN && (!out_valid || !out_stall)) begin
      smoothed_angle <= res;
    end
  end

endmodule
`default_nettype wire

/* src/amavg_window.sv */
// Sample window: WINDOW_DEPTH angle entries, oldest first, and the fill count.
// Depends on amavg_pkg.
`default_nettype none
module amavg_window (
  input  wire                  clk,
  input  wire                  rst,
  input  amavg_pkg::win_cmd_t  cmd,
  input  amavg_pkg::idx_t      rd_idx,
  output amavg_pkg::angle_t    rd_data,
  output amavg_pkg::cnt_t      count
);
  import amavg_pkg::*;

  angle_t entry [WINDOW_DEPTH];
  logic   full;

  assign full    = (count >= CNT_W'(WINDOW_DEPTH));
  assign rd_data = entry[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.upd) begin
      if (cmd.clr == REQ_CLEAR) begin
        count <= '0;
      end else if (!full) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && (cmd.clr == REQ_ADD)) begin
      if (!full) begin
        entry[count[IDX_W-1:0]] <= cmd.angle;
      end else begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          entry[i] <= entry[i+1];
        end
        entry[WINDOW_DEPTH-1] <= cmd.angle;
      end
    end
  end

endmodule
`default_nettype wire

/* src/amavg_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on amavg_pkg.
`default_nettype none
module amavg_div (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  amavg_pkg::sum_t  dividend,
  input  amavg_pkg::cnt_t  divisor,
  output logic             done,
  output amavg_pkg::sum_t  quotient
);
  import amavg_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] steps;
  cnt_t              rem;
  cnt_t              rem_next;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  always_comb begin
    trial    = {rem, quotient[SUM_W-1]};
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= rem_next;
    end
  end

endmodule
`default_nettype wire
